/* sv/gqtr_pkg.sv */
// ----------------------------------------------------------------------------
// Grid quarter-turn rotator package
// Shared constants, operation codes and transaction types of the rotator.
// ----------------------------------------------------------------------------
package gqtr_pkg;

  localparam int unsigned MaxDimDefault = 32;
  localparam int unsigned CfgDataW      = 6;
  localparam int unsigned CfgIndexW     = 2;
  localparam int unsigned WrIndexW      = 11;
  localparam int unsigned OpW           = 3;
  localparam int unsigned PixelW        = 8;

  typedef enum logic [OpW-1:0] {
    OP_WRITE = 3'd0,
    OP_LEFT  = 3'd1,
    OP_RIGHT = 3'd2,
    OP_READ  = 3'd3,
    OP_START = 3'd4
  } op_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1
  } cfg_idx_e;

  localparam logic [PixelW-1:0] CharDash  = 8'h2D;
  localparam logic [PixelW-1:0] CharBar   = 8'h7C;
  localparam logic [PixelW-1:0] CharPlus  = 8'h2B;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [PixelW-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PixelW-1:0]   pixel_out;
    logic [CfgDataW-1:0] out_rows;
    logic [CfgDataW-1:0] out_cols;
    logic                row_end;
    logic                frame_end;
  } out_item_t;

  function automatic logic [PixelW-1:0] swap_mark(logic [PixelW-1:0] c);
    logic [PixelW-1:0] r;
    if (c == CharDash) begin
      r = CharBar;
    end else if (c == CharBar) begin
      r = CharDash;
    end else begin
      r = CharPlus;
    end
    return r;
  endfunction

endpackage

/* sv/grid_quarter_turn_rotator.sv */
// ----------------------------------------------------------------------------
// Grid quarter-turn rotator
// Frame store for a character grid with readout rotated in quarter turns.
// ----------------------------------------------------------------------------
// The input channel (in_valid_i, in_stall_o, in_item_i) carries one command per
// transaction: write a character in raster order, turn left, turn right, read
// the next character of the rotated grid, or start a new frame. Only a read
// produces a transaction on the output channel (out_valid_o, out_stall_i,
// out_item_o); it passes through the read-data register and then the output register.
// Unless the input channel is stalled, one command is taken per cycle and loads and
// readout run at one character per clock; the frame store has one write port and one registered read port.
// The configuration channel sets the source row and column counts. A write
// of the column count re-derives the write position from the raster index
// with a bit-serial divider, and the input channel is stalled while it runs.
// Reset clears the turn direction, the write and read positions and sets both
// dimensions to one; the frame store contents are undefined until written.
// When the receiver stalls, the output register and one stage behind it hold
// their results, after which the input channel is stalled as well.
// ----------------------------------------------------------------------------
module grid_quarter_turn_rotator #(
  parameter int unsigned MAX_DIM = gqtr_pkg::MaxDimDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gqtr_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [gqtr_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  gqtr_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output gqtr_pkg::out_item_t                 out_item_o
);

  localparam int unsigned DW    = $clog2(MAX_DIM + 1);
  localparam int unsigned RW    = $clog2(MAX_DIM);
  localparam int unsigned Depth = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned WW    = gqtr_pkg::WrIndexW;
  localparam int unsigned LW    = WW + 2 * DW;
  localparam int unsigned CntW  = $clog2(WW + 1);
  localparam int unsigned CW    = gqtr_pkg::CfgDataW;
  localparam int unsigned PW    = gqtr_pkg::PixelW;

  function automatic logic [DW-1:0] clamp_dim(logic [CW-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (int'(v) > int'(MAX_DIM)) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  logic [CW-1:0]   rows_q, cols_q;
  logic [1:0]      dir_q;
  logic [WW-1:0]   wi_q;
  logic [WW-1:0]   wrow_q;
  logic [DW-1:0]   wcol_q;
  logic [RW-1:0]   rr_q, rc_q;
  logic            div_busy_q;
  logic [CntW-1:0] div_cnt_q;
  logic            s1_v_q, out_v_q;
  logic            s1_odd_q, s1_rend_q, s1_fend_q;
  logic [CW-1:0]   s1_rows_q, s1_cols_q;
  logic [PW-1:0]   rdata_q;
  gqtr_pkg::out_item_t out_q;
  logic [PW-1:0]   mem_q [Depth];

  logic [DW-1:0]   n_dim, m_dim, orows, ocols;
  logic [2*DW-1:0] area;
  logic            odd, wrap, rend, fend;
  logic [DW-1:0]   i_pos, k_pos, src_row, src_col;
  logic [AW-1:0]   raddr, waddr;
  logic            s1_go, in_acc, rd_acc, wr_ok, cols_wr;
  logic [DW:0]     rem_sh;
  logic            rem_ge;
  logic [DW-1:0]   rem_nx;

  assign cfg_ready_o = 1'b1;
  assign cols_wr     = cfg_valid_i && (cfg_index_i == gqtr_pkg::CFG_COLS);

  assign n_dim = clamp_dim(rows_q);
  assign m_dim = clamp_dim(cols_q);
  assign area  = (2*DW)'(n_dim) * (2*DW)'(m_dim);

  assign s1_go      = !out_v_q || !out_stall_i;
  assign in_stall_o = div_busy_q || cfg_valid_i || (s1_v_q && !s1_go);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign rd_acc     = in_acc && (in_item_i.operation == gqtr_pkg::OP_READ);
  assign wr_ok      = in_acc && (in_item_i.operation == gqtr_pkg::OP_WRITE)
                      && (LW'(wi_q) < LW'(area));
  assign waddr      = AW'(wrow_q) * AW'(MAX_DIM) + AW'(wcol_q);

  always_comb begin
    odd   = dir_q[0];
    orows = odd ? m_dim : n_dim;
    ocols = odd ? n_dim : m_dim;
    wrap  = (DW'(rr_q) >= orows) || (DW'(rc_q) >= ocols);
    i_pos = wrap ? '0 : DW'(rr_q);
    k_pos = wrap ? '0 : DW'(rc_q);
    rend  = (k_pos + DW'(1)) == ocols;
    fend  = rend && ((i_pos + DW'(1)) == orows);
    case (dir_q)
      2'd0: begin
        src_row = i_pos;
        src_col = k_pos;
      end
      2'd1: begin
        src_row = n_dim - DW'(1) - k_pos;
        src_col = i_pos;
      end
      2'd2: begin
        src_row = n_dim - DW'(1) - i_pos;
        src_col = m_dim - DW'(1) - k_pos;
      end
      default: begin
        src_row = k_pos;
        src_col = m_dim - DW'(1) - i_pos;
      end
    endcase
    raddr = AW'(src_row) * AW'(MAX_DIM) + AW'(src_col);
  end

  always_comb begin
    rem_sh = {wcol_q, wrow_q[WW-1]};
    rem_ge = rem_sh >= {1'b0, m_dim};
    rem_nx = rem_ge ? DW'(rem_sh - {1'b0, m_dim}) : DW'(rem_sh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     <= CW'(1);
      cols_q     <= CW'(1);
      dir_q      <= '0;
      wi_q       <= '0;
      wrow_q     <= '0;
      wcol_q     <= '0;
      rr_q       <= '0;
      rc_q       <= '0;
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
      s1_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      s1_v_q  <= rd_acc || (s1_v_q && !s1_go);
      out_v_q <= (s1_v_q && s1_go) || (out_v_q && out_stall_i);
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          gqtr_pkg::CFG_ROWS: rows_q <= cfg_data_i;
          gqtr_pkg::CFG_COLS: cols_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cols_wr) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= CntW'(WW);
        wrow_q     <= wi_q;
        wcol_q     <= '0;
      end else if (div_busy_q) begin
        wrow_q    <= {wrow_q[WW-2:0], rem_ge};
        wcol_q    <= rem_nx;
        div_cnt_q <= div_cnt_q - CntW'(1);
        if (div_cnt_q == CntW'(1)) begin
          div_busy_q <= 1'b0;
        end
      end else if (in_acc) begin
        unique case (in_item_i.operation)
          gqtr_pkg::OP_WRITE: begin
            if (wr_ok) begin
              wi_q <= wi_q + WW'(1);
              if (wi_q == '1) begin
                wrow_q <= '0;
                wcol_q <= '0;
              end else if ((wcol_q + DW'(1)) == m_dim) begin
                wcol_q <= '0;
                wrow_q <= wrow_q + WW'(1);
              end else begin
                wcol_q <= wcol_q + DW'(1);
              end
            end
          end
          gqtr_pkg::OP_LEFT:  dir_q <= dir_q - 2'd1;
          gqtr_pkg::OP_RIGHT: dir_q <= dir_q + 2'd1;
          gqtr_pkg::OP_READ: begin
            if (rend) begin
              rc_q <= '0;
              rr_q <= fend ? '0 : RW'(i_pos + DW'(1));
            end else begin
              rr_q <= RW'(i_pos);
              rc_q <= RW'(k_pos + DW'(1));
            end
          end
          gqtr_pkg::OP_START: begin
            dir_q  <= '0;
            wi_q   <= '0;
            wrow_q <= '0;
            wcol_q <= '0;
            rr_q   <= '0;
            rc_q   <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[waddr] <= in_item_i.pixel_in;
    end
    if (rd_acc) begin
      rdata_q   <= mem_q[raddr];
      s1_odd_q  <= odd;
      s1_rows_q <= CW'(orows);
      s1_cols_q <= CW'(ocols);
      s1_rend_q <= rend;
      s1_fend_q <= fend;
    end
    if (s1_v_q && s1_go) begin
      out_q.pixel_out <= s1_odd_q ? gqtr_pkg::swap_mark(rdata_q) : rdata_q;
      out_q.out_rows  <= s1_rows_q;
      out_q.out_cols  <= s1_cols_q;
      out_q.row_end   <= s1_rend_q;
      out_q.frame_end <= s1_fend_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_div_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |-> in_stall_o)
    else $error("Input accepted while the write position is being recomputed.");

  a_wcol_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !div_busy_q |-> (wcol_q < m_dim))
    else $error("Write column is outside the configured column count.");

  a_frame_end_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (!out_q.frame_end || out_q.row_end))
    else $error("Frame end flagged on a character that does not end a row.");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && out_v_q && out_stall_i) |=> s1_v_q && out_v_q)
    else $error("A pending read result was dropped under a stalled output.");
`endif

endmodule
